// ----- src/ezpm_pkg.sv -----
// Shared types, constants and arithmetic helpers for the Euler pose matrix block.
package ezpm_pkg;

    localparam int ANGLE_WIDTH = 16;
    localparam int ANGLE_SHIFT = 33 - ANGLE_WIDTH;
    localparam int Z_W         = 35;
    localparam int XY_W        = 34;
    localparam int SC_W        = 32;
    localparam int STEPS       = 20;
    localparam int POS_W       = 32;
    localparam int ENT_W       = 16;
    localparam int S_BITS      = 3 * POS_W + 3 * ANGLE_WIDTH;
    localparam int S_W         = ((S_BITS + 7) / 8) * 8;
    localparam int M_W         = 9 * ENT_W + 3 * POS_W;
    localparam int Q_DEPTH     = 4;
    localparam int Q_AW        = 2;
    localparam int LAST_ST     = 24;

    localparam logic signed [Z_W-1:0]  HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [Z_W-1:0]  PI_Q30      = 35'sd3373259426;
    localparam logic signed [XY_W-1:0] CORDIC_X0   = 34'sd652032874;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [Z_W-1:0]   z_roll;
        logic signed [Z_W-1:0]   z_pitch;
        logic signed [Z_W-1:0]   z_yaw;
        logic                    flip_roll;
        logic                    flip_pitch;
        logic                    flip_yaw;
    } t_item;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } t_pos;

    function automatic logic signed [Z_W-1:0] f_atan(input int i);
        logic signed [Z_W-1:0] r;
        unique case (i)
            0:  r = 35'sd843314856;
            1:  r = 35'sd497837829;
            2:  r = 35'sd263043836;
            3:  r = 35'sd133525158;
            4:  r = 35'sd67021686;
            5:  r = 35'sd33543515;
            6:  r = 35'sd16775850;
            7:  r = 35'sd8388437;
            8:  r = 35'sd4194282;
            9:  r = 35'sd2097149;
            10: r = 35'sd1048575;
            11: r = 35'sd524287;
            12: r = 35'sd262143;
            13: r = 35'sd131071;
            14: r = 35'sd65535;
            15: r = 35'sd32767;
            16: r = 35'sd16383;
            17: r = 35'sd8191;
            18: r = 35'sd4095;
            19: r = 35'sd2047;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [Z_W-1:0] f_reduce(input logic signed [ANGLE_WIDTH-1:0] a,
                                                         output logic flip);
        logic signed [Z_W-1:0] v;
        logic signed [Z_W-1:0] r;
        v = Z_W'(a) <<< ANGLE_SHIFT;
        flip = 1'b0;
        r = v;
        if (v > HALF_PI_Q30) begin
            r = v - PI_Q30;
            flip = 1'b1;
        end else if (v < -HALF_PI_Q30) begin
            r = v + PI_Q30;
            flip = 1'b1;
        end
        return r;
    endfunction

    // round half up from Q60 to Q14, clamp to +-1.0
    function automatic logic signed [ENT_W-1:0] f_rsat(input logic signed [63:0] v);
        logic signed [64:0] t;
        logic signed [18:0] r;
        logic signed [ENT_W-1:0] o;
        t = 65'(v) + (65'sd1 <<< 45);
        r = 19'(t >>> 46);
        if (r > 19'sd16384)
            o = 16'sd16384;
        else if (r < -19'sd16384)
            o = -16'sd16384;
        else
            o = r[ENT_W-1:0];
        return o;
    endfunction

endpackage

// ----- src/euler_zyx_pose_matrix.sv -----
// Top level: Z-Y-X Euler pose to rotation matrix with position pass-through.
//
// Usage:
//   Slave channel (s_axis_*) takes one pose request per handshake: position x,y,z
//   and roll, pitch, yaw angles in signed Q2.13 radians.
//   Master channel (m_axis_*) returns one result per request: the nine rotation
//   entries of Rz*Ry*Rx in signed Q1.14, row-major, then the unchanged position.
//   Throughput: one request per cycle while the receiver accepts, set by the fully pipelined 20-step
//   CORDIC units and the two multiplier stages behind them.
//   A four-entry queue sits between the angle reduction front end and the
//   arithmetic pipeline, so s_axis_tready stays high while the back end drains.
//   When the receiver stalls the whole back end holds; the queue then fills and
//   s_axis_tready drops once it holds four requests.
//   Reset (i_rst_n low, synchronous) empties the queue and clears all valids;
//   results in flight are dropped.
module euler_zyx_pose_matrix
    import ezpm_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    // pos_x, pos_y, pos_z, roll, pitch, yaw (lowest bit up)
    input  logic [S_W-1:0] s_axis_tdata,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22, out_x, out_y, out_z (lowest bit up)
    output logic [M_W-1:0] m_axis_tdata
);

    t_item item;
    logic  q_vld, pop;

    ezpm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_pos_x (s_axis_tdata[POS_W-1:0]),
        .i_pos_y (s_axis_tdata[2*POS_W-1:POS_W]),
        .i_pos_z (s_axis_tdata[3*POS_W-1:2*POS_W]),
        .i_roll  (s_axis_tdata[3*POS_W+ANGLE_WIDTH-1:3*POS_W]),
        .i_pitch (s_axis_tdata[3*POS_W+2*ANGLE_WIDTH-1:3*POS_W+ANGLE_WIDTH]),
        .i_yaw   (s_axis_tdata[3*POS_W+3*ANGLE_WIDTH-1:3*POS_W+2*ANGLE_WIDTH]),
        .o_vld   (q_vld),
        .o_item  (item),
        .i_pop   (pop)
    );

    ezpm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (q_vld),
        .i_item  (item),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

endmodule

// ----- src/ezpm_front.sv -----
// Front end: range-reduces the angles and holds requests in a short queue.
module ezpm_front
    import ezpm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic signed [POS_W-1:0] i_pos_x,
    input  logic signed [POS_W-1:0] i_pos_y,
    input  logic signed [POS_W-1:0] i_pos_z,
    input  logic signed [ANGLE_WIDTH-1:0] i_roll,
    input  logic signed [ANGLE_WIDTH-1:0] i_pitch,
    input  logic signed [ANGLE_WIDTH-1:0] i_yaw,
    output logic                   o_vld,
    output t_item                  o_item,
    input  logic                   i_pop
);

    t_item             r_q [0:Q_DEPTH-1];
    logic [Q_AW-1:0]   r_wr, r_rd;
    logic [Q_AW:0]     r_cnt;
    t_item             n_item;
    logic              fr, fp, fy;
    logic              push, pop;

    always_comb begin
        n_item.pos_x      = i_pos_x;
        n_item.pos_y      = i_pos_y;
        n_item.pos_z      = i_pos_z;
        n_item.z_roll     = f_reduce(i_roll, fr);
        n_item.z_pitch    = f_reduce(i_pitch, fp);
        n_item.z_yaw      = f_reduce(i_yaw, fy);
        n_item.flip_roll  = fr;
        n_item.flip_pitch = fp;
        n_item.flip_yaw   = fy;
    end

    assign o_ready = (r_cnt != (Q_AW+1)'(Q_DEPTH));
    assign o_vld   = (r_cnt != '0);
    assign o_item  = r_q[r_rd];
    assign push    = i_valid & o_ready;
    assign pop     = i_pop & o_vld;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (pop)  r_rd <= r_rd + 1'b1;
            if (push && !pop)
                r_cnt <= r_cnt + 1'b1;
            else if (pop && !push)
                r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

// ----- src/ezpm_cordic.sv -----
// Pipelined rotation-mode CORDIC giving sine and cosine of one reduced angle.
module ezpm_cordic
    import ezpm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [Z_W-1:0] i_z,
    input  logic                  i_flip,
    output logic signed [SC_W-1:0] o_sin,
    output logic signed [SC_W-1:0] o_cos
);

    logic signed [XY_W-1:0] r_x [0:STEPS];
    logic signed [XY_W-1:0] r_y [0:STEPS];
    logic signed [Z_W-1:0]  r_z [0:STEPS];
    logic                   r_f [0:STEPS];
    logic signed [SC_W-1:0] r_s, r_c;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= CORDIC_X0;
            r_y[0] <= '0;
            r_z[0] <= i_z;
            r_f[0] <= i_flip;
            for (int i = 0; i < STEPS; i++) begin
                r_f[i+1] <= r_f[i];
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - f_atan(i);
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + f_atan(i);
                end
            end
            r_c <= r_f[STEPS] ? -r_x[STEPS][SC_W-1:0] : r_x[STEPS][SC_W-1:0];
            r_s <= r_f[STEPS] ? -r_y[STEPS][SC_W-1:0] : r_y[STEPS][SC_W-1:0];
        end
    end

    assign o_sin = r_s;
    assign o_cos = r_c;

endmodule

// ----- src/ezpm_back.sv -----
// Back end: three CORDICs, the matrix products and the output register.
module ezpm_back
    import ezpm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_vld,
    input  t_item        i_item,
    output logic         o_pop,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [M_W-1:0] o_data
);

    logic                   en;
    logic                   r_vld [0:LAST_ST];
    t_pos                   r_pos [0:LAST_ST];
    logic signed [SC_W-1:0] sx, cx, sy, cy, sz, cz;
    logic signed [63:0]     p_czsy, p_szsy;

    logic signed [63:0] r_czcy, r_szcy, r_cysx, r_cycx, r_szcx, r_szsx, r_czcx, r_czsx;
    logic signed [SC_W-1:0] r_czsy, r_szsy, r_sx, r_cx, r_sy;

    logic signed [63:0] r2_czcy, r2_szcy, r2_cysx, r2_cycx, r2_szcx, r2_szsx, r2_czcx, r2_czsx;
    logic signed [63:0] r2_q1, r2_q2, r2_q3, r2_q4, r2_msy;

    logic signed [ENT_W-1:0] r_m [0:8];

    assign en    = !r_vld[LAST_ST] || i_ready;
    assign o_pop = en;

    ezpm_cordic u_roll  (.i_clk(i_clk), .i_en(en), .i_z(i_item.z_roll),
                         .i_flip(i_item.flip_roll), .o_sin(sx), .o_cos(cx));
    ezpm_cordic u_pitch (.i_clk(i_clk), .i_en(en), .i_z(i_item.z_pitch),
                         .i_flip(i_item.flip_pitch), .o_sin(sy), .o_cos(cy));
    ezpm_cordic u_yaw   (.i_clk(i_clk), .i_en(en), .i_z(i_item.z_yaw),
                         .i_flip(i_item.flip_yaw), .o_sin(sz), .o_cos(cz));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LAST_ST; k++) r_vld[k] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_vld;
            for (int k = 1; k <= LAST_ST; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    assign p_czsy = 64'(cz) * 64'(sy) + (64'sd1 <<< 29);
    assign p_szsy = 64'(sz) * 64'(sy) + (64'sd1 <<< 29);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pos[0] <= '{pos_x: i_item.pos_x, pos_y: i_item.pos_y, pos_z: i_item.pos_z};
            for (int k = 1; k <= LAST_ST; k++) r_pos[k] <= r_pos[k-1];

            r_czcy <= 64'(cz) * 64'(cy);
            r_szcy <= 64'(sz) * 64'(cy);
            r_cysx <= 64'(cy) * 64'(sx);
            r_cycx <= 64'(cy) * 64'(cx);
            r_szcx <= 64'(sz) * 64'(cx);
            r_szsx <= 64'(sz) * 64'(sx);
            r_czcx <= 64'(cz) * 64'(cx);
            r_czsx <= 64'(cz) * 64'(sx);
            r_czsy <= SC_W'(p_czsy >>> 30);
            r_szsy <= SC_W'(p_szsy >>> 30);
            r_sx   <= sx;
            r_cx   <= cx;
            r_sy   <= sy;

            r2_czcy <= r_czcy;
            r2_szcy <= r_szcy;
            r2_cysx <= r_cysx;
            r2_cycx <= r_cycx;
            r2_szcx <= r_szcx;
            r2_szsx <= r_szsx;
            r2_czcx <= r_czcx;
            r2_czsx <= r_czsx;
            r2_q1   <= 64'(r_czsy) * 64'(r_sx);
            r2_q2   <= 64'(r_czsy) * 64'(r_cx);
            r2_q3   <= 64'(r_szsy) * 64'(r_sx);
            r2_q4   <= 64'(r_szsy) * 64'(r_cx);
            r2_msy  <= -(64'(r_sy) <<< 30);

            r_m[0] <= f_rsat(r2_czcy);
            r_m[1] <= f_rsat(r2_q1 - r2_szcx);
            r_m[2] <= f_rsat(r2_q2 + r2_szsx);
            r_m[3] <= f_rsat(r2_szcy);
            r_m[4] <= f_rsat(r2_q3 + r2_czcx);
            r_m[5] <= f_rsat(r2_q4 - r2_czsx);
            r_m[6] <= f_rsat(r2_msy);
            r_m[7] <= f_rsat(r2_cysx);
            r_m[8] <= f_rsat(r2_cycx);
        end
    end

    assign o_valid = r_vld[LAST_ST];
    assign o_data  = {r_pos[LAST_ST].pos_z, r_pos[LAST_ST].pos_y, r_pos[LAST_ST].pos_x,
                      r_m[8], r_m[7], r_m[6], r_m[5], r_m[4], r_m[3], r_m[2], r_m[1], r_m[0]};

endmodule

// ----- tb/euler_zyx_pose_matrix_tb.sv -----
// Testbench for the Euler pose matrix block: directed table then random poses, scoreboarded.
module euler_zyx_pose_matrix_tb;
    import ezpm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] px, py, pz;
        logic [15:0] roll, pitch, yaw;
    } t_pose;

    typedef struct {
        t_pose       p;
        logic        has_exp;
        logic [15:0] e00;
        logic [15:0] e20;
    } t_row;

    logic           i_clk;
    logic           i_rst_n;
    logic           s_tvalid;
    logic           s_tready;
    logic [S_W-1:0] s_tdata;
    logic           m_tvalid;
    logic           m_tready;
    logic [M_W-1:0] m_tdata;

    logic [M_W-1:0] matrix_q[$];
    int             mismatches;
    t_row           rows[$];
    t_pose          poses[$];

    euler_zyx_pose_matrix DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [15:0] q14(longint v);
        longint r;
        r = (v + (64'sd1 <<< 45)) >>> 46;
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return r[15:0];
    endfunction

    function automatic void trig(logic [15:0] raw, output longint s, output longint c);
        longint atans[20] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                              33543515, 16775850, 8388437, 4194282, 2097149,
                              1048575, 524287, 262143, 131071, 65535,
                              32767, 16383, 8191, 4095, 2047};
        longint z, x, y, nx;
        bit     flip;
        z = longint'($signed(raw)) * 131072;
        x = 652032874;
        y = 0;
        flip = 0;
        if (z > 1686629713) begin
            z -= 64'sd3373259426;
            flip = 1;
        end else if (z < -1686629713) begin
            z += 64'sd3373259426;
            flip = 1;
        end
        for (int i = 0; i < 20; i++) begin
            if (z >= 0) begin
                nx = x - shr(y, i);
                y  = y + shr(x, i);
                z -= atans[i];
            end else begin
                nx = x + shr(y, i);
                y  = y - shr(x, i);
                z += atans[i];
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic logic [M_W-1:0] pose_matrix(t_pose p);
        longint sx, cx, sy, cy, sz, cz, czsy, szsy, r;
        logic [15:0] e[9];
        trig(p.roll, sx, cx);
        trig(p.pitch, sy, cy);
        trig(p.yaw, sz, cz);
        czsy = (cz * sy + (64'sd1 <<< 29)) >>> 30;
        szsy = (sz * sy + (64'sd1 <<< 29)) >>> 30;
        e[0] = q14(cz * cy);
        e[1] = q14(czsy * sx - sz * cx);
        e[2] = q14(czsy * cx + sz * sx);
        e[3] = q14(sz * cy);
        e[4] = q14(szsy * sx + cz * cx);
        e[5] = q14(szsy * cx - cz * sx);
        r = (-sy + 32768) >>> 16;
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        e[6] = r[15:0];
        e[7] = q14(cy * sx);
        e[8] = q14(cy * cx);
        return {p.pz, p.py, p.px, e[8], e[7], e[6], e[5], e[4], e[3], e[2], e[1], e[0]};
    endfunction

    function automatic t_pose rand_pose();
        t_pose p;
        int    k;
        p.px = $urandom;
        p.py = $urandom;
        p.pz = $urandom;
        k = $urandom_range(0, 3);
        p.roll  = (k == 0) ? 16'($urandom_range(0, 1) ? 32767 - $urandom_range(0, 3) :
                                32768 + $urandom_range(0, 3)) : 16'($urandom);
        p.pitch = 16'($urandom);
        p.yaw   = (k == 1) ? 16'(($urandom_range(0, 1) ? 12868 : -12868) +
                               $signed($urandom_range(0, 8)) - 4) : 16'($urandom);
        return p;
    endfunction

    function automatic t_row mk(logic [31:0] px, logic [15:0] r, logic [15:0] pt,
                                logic [15:0] y, logic he, logic [15:0] e00, logic [15:0] e20);
        t_row w;
        w.p = '{px, ~px, px ^ 32'h5a5a_a5a5, r, pt, y};
        w.has_exp = he;
        w.e00 = e00;
        w.e20 = e20;
        return w;
    endfunction

    initial begin
        rows = {rows, mk(32'h0, 16'h0, 16'h0, 16'h0, 1'b1, 16'sd16384, 16'sd0)};
        rows = {rows, mk(32'h7fff_ffff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0, 16'h0, 16'h0)};
        rows = {rows, mk(32'h8000_0000, 16'h8000, 16'h8000, 16'h8000, 1'b0, 16'h0, 16'h0)};
        rows = {rows, mk(32'hffff_ffff, 16'hffff, 16'h0001, 16'hffff, 1'b0, 16'h0, 16'h0)};
        rows = {rows, mk(32'h1234_5678, 16'sd12868, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0)};
        rows = {rows, mk(32'h1, 16'h0, 16'sd12868, 16'h0, 1'b0, 16'h0, 16'h0)};
        rows = {rows, mk(32'h2, 16'h0, -16'sd12868, 16'h0, 1'b0, 16'h0, 16'h0)};
        rows = {rows, mk(32'h3, 16'h0, 16'sd12867, 16'sd12869, 1'b0, 16'h0, 16'h0)};
        rows = {rows, mk(32'h4, 16'sd25736, 16'sd25736, 16'sd25736, 1'b0, 16'h0, 16'h0)};
        rows = {rows, mk(32'h5, -16'sd25736, -16'sd12869, 16'sd6434, 1'b0, 16'h0, 16'h0)};
        rows = {rows, mk(32'haaaa_aaaa, 16'haaaa, 16'h5555, 16'haaaa, 1'b0, 16'h0, 16'h0)};
        rows = {rows, mk(32'h5555_5555, 16'h5555, 16'haaaa, 16'h5555, 1'b0, 16'h0, 16'h0)};
        foreach (rows[i]) poses = {poses, rows[i].p};
        for (int i = 0; i < 1100; i++) poses = {poses, rand_pose()};
    end

    initial begin
        int idx;
        int gap;
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        mismatches = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        idx = 0;
        while (idx < poses.size()) begin
            for (int b = $urandom_range(1, 20); b > 0 && idx < poses.size(); b--) begin
                s_tvalid = 1'b1;
                s_tdata  = S_W'({poses[idx].yaw, poses[idx].pitch, poses[idx].roll,
                                 poses[idx].pz, poses[idx].py, poses[idx].px});
                @(posedge i_clk);
                while (!s_tready) @(posedge i_clk);
                if (idx < rows.size() && rows[idx].has_exp) begin
                    logic [M_W-1:0] e;
                    e = pose_matrix(poses[idx]);
                    if (e[15:0] != rows[idx].e00 || e[111:96] != rows[idx].e20) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("table row %0d expected %h %h predictor %h %h", idx,
                                     rows[idx].e00, rows[idx].e20, e[15:0], e[111:96]);
                    end
                    e[15:0]   = rows[idx].e00;
                    e[111:96] = rows[idx].e20;
                    matrix_q = {matrix_q, e};
                end else begin
                    matrix_q = {matrix_q, pose_matrix(poses[idx])};
                end
                idx++;
                @(negedge i_clk);
            end
            s_tvalid = 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) @(negedge i_clk);
        end
        while (matrix_q.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            case ($urandom_range(0, 3))
                0: m_tready = 1'b0;
                default: m_tready = 1'b1;
            endcase
            if ($urandom_range(0, 50) == 0) begin
                m_tready = 1'b1;
                repeat ($urandom_range(20, 60)) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (matrix_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_tdata);
            end else begin
                logic [M_W-1:0] e;
                e = matrix_q.pop_front();
                for (int f = 0; f < 12; f++) begin
                    logic [31:0] ev, av;
                    ev = (f < 9) ? 32'(e[f*16 +: 16]) : e[144 + (f-9)*32 +: 32];
                    av = (f < 9) ? 32'(m_tdata[f*16 +: 16]) : m_tdata[144 + (f-9)*32 +: 32];
                    if (ev != av) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("field %0d expected %h got %h", f, ev, av);
                    end
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end
endmodule
